// ===== hdl/gpsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpsp_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_LAT    = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_LON    = 3'd1;
    localparam t_cfg_idx CFG_HEADING_EAST  = 3'd2;
    localparam t_cfg_idx CFG_HEADING_NORTH = 3'd3;
    localparam t_cfg_idx CFG_TRACK_UP      = 3'd4;
    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 3'd5;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 3'd6;
    localparam t_cfg_idx CFG_ZOOM_LEVEL    = 3'd7;

    // long division by a small constant: 7 quotient bits per stage
    localparam int unsigned DIV_W      = 42;
    localparam int unsigned REM_W      = 10;
    localparam int unsigned STEP_BITS  = 7;
    localparam int unsigned DIV_STAGES = DIV_W / STEP_BITS;
    localparam int unsigned TAG_W      = 3;

    // fractional part of the Q32 factor that turns latitude into a Q30 angle (the integer part is 2^32)
    localparam logic [31:0] ANGLE_FRAC = 32'd3753943213;
    localparam logic [13:0] CM_NUM     = 14'd11132;
    localparam logic [9:0]  CM_DEN_ODD = 10'd625;      // 10000 = 16 * 625
    localparam logic [15:0] SCREEN_LIM = 16'd30000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] word;
    } t_div_lane;

    function automatic t_div_lane div_step(t_div_lane s, logic [REM_W-1:0] d);
        t_div_lane o;
        logic [REM_W:0] t;
        o = s;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {o.rem, o.word[DIV_W-1]};
            if (t >= {1'b0, d}) begin
                o.rem  = REM_W'(t - {1'b0, d});
                o.word = {o.word[DIV_W-2:0], 1'b1};
            end else begin
                o.rem  = t[REM_W-1:0];
                o.word = {o.word[DIV_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Horner coefficients, highest order first (Q30)
    function automatic logic signed [31:0] cos_coef(logic [2:0] k);
        case (k)
            3'd0:    return -32'sd296;
            3'd1:    return 32'sd26631;
            3'd2:    return -32'sd1491308;
            3'd3:    return 32'sd44739243;
            3'd4:    return -32'sd536870912;
            default: return 32'sd1073741824;
        endcase
    endfunction

    function automatic logic [9:0] zoom_metres(logic [2:0] z);
        case (z)
            3'd0:    return 10'd20;
            3'd1:    return 10'd50;
            3'd2:    return 10'd100;
            3'd3:    return 10'd200;
            3'd4:    return 10'd500;
            default: return 10'd1000;
        endcase
    endfunction

    // metres * 2048 = 2^shift * odd part
    function automatic logic [3:0] zoom_shift(logic [2:0] z);
        case (z)
            3'd0:    return 4'd13;
            3'd1:    return 4'd12;
            3'd2:    return 4'd13;
            3'd3:    return 4'd14;
            3'd4:    return 4'd13;
            default: return 4'd14;
        endcase
    endfunction

    function automatic logic [9:0] zoom_odd(logic [2:0] z);
        case (z)
            3'd0:    return 10'd5;
            3'd1:    return 10'd25;
            3'd2:    return 10'd25;
            3'd3:    return 10'd25;
            default: return 10'd125;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gpsp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gpsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] point_lat;
    logic signed [31:0] point_lon;
    logic               last_point;

    modport source (output valid, point_lat, point_lon, last_point, input ready);
    modport sink   (input valid, point_lat, point_lon, last_point, output ready);
endinterface

`default_nettype wire

// ===== hdl/gpsp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gpsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               result_valid;
    logic               last_result;

    modport source (output valid, screen_x, screen_y, result_valid, last_result, input ready);
    modport sink   (input valid, screen_x, screen_y, result_valid, last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/gpsp_cos.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: cos(origin latitude) in Q2.16, returned as |cos| * 11132 and a sign.
module gpsp_cos import gpsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [30:0] i_lat,
    output logic               o_busy,
    output logic [29:0]        o_coef,
    output logic               o_coef_neg
);

    typedef enum logic [2:0] {
        S_IDLE, S_ANGLE, S_X, S_SQ, S_Z, S_MUL, S_ADD, S_FIN
    } t_state;

    t_state             r_state;
    logic signed [65:0] r_prod;
    logic [30:0]        r_x;
    logic [31:0]        r_z;
    logic signed [31:0] r_r;
    logic [2:0]         r_k;
    logic [29:0]        r_coef;
    logic               r_neg;

    logic [30:0]        w_abs;
    logic [62:0]        w_ang;
    logic [61:0]        w_sq;
    logic signed [65:0] w_zr;
    logic signed [65:0] w_bias;
    logic signed [65:0] w_sh;
    logic signed [31:0] w_cb;
    logic signed [31:0] w_cos;
    logic [16:0]        w_cabs;
    logic [30:0]        w_coef;

    assign w_abs  = i_lat[30] ? 31'(~i_lat + 31'sd1) : 31'(i_lat);
    assign w_ang  = w_abs * ANGLE_FRAC;
    assign w_sq   = r_x * r_x;
    assign w_zr   = $signed({1'b0, r_z}) * r_r;
    // truncate toward zero on divide by 2^30
    assign w_bias = r_prod + (r_prod[65] ? 66'sd1073741823 : 66'sd0);
    assign w_sh   = w_bias >>> 30;
    assign w_cb   = r_r + (r_r[31] ? 32'sd16383 : 32'sd0);
    assign w_cos  = w_cb >>> 14;
    assign w_cabs = w_cos[31] ? 17'(-w_cos) : w_cos[16:0];
    assign w_coef = w_cabs * CM_NUM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ANGLE;
        end else if (i_start) begin
            r_state <= S_ANGLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_ANGLE: begin
                    r_prod  <= $signed({3'b0, w_ang});
                    r_state <= S_X;
                end
                S_X: begin
                    r_x     <= w_abs + r_prod[62:32];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_prod  <= $signed({4'b0, w_sq});
                    r_state <= S_Z;
                end
                S_Z: begin
                    r_z     <= r_prod[61:30];
                    r_r     <= 32'sd2;
                    r_k     <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_zr;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_r <= cos_coef(r_k) + $signed(w_sh[31:0]);
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    r_coef  <= w_coef[29:0];
                    r_neg   <= w_cos[31];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_coef     = r_coef;
    assign o_coef_neg = r_neg;

endmodule

`default_nettype wire

// ===== hdl/gpsp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-lane pipelined restoring division by a small divisor, tag travels along.
module gpsp_div import gpsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [DIV_W-1:0] i_num_a,
    input  logic [DIV_W-1:0] i_num_b,
    input  logic [REM_W-1:0] i_den,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_tag,
    output logic [DIV_W-1:0] o_quo_a,
    output logic [DIV_W-1:0] o_quo_b
);

    t_div_lane              r_a   [DIV_STAGES];
    t_div_lane              r_b   [DIV_STAGES];
    t_div_lane              n_a   [DIV_STAGES];
    t_div_lane              n_b   [DIV_STAGES];
    logic [TAG_W-1:0]       r_tag [DIV_STAGES];
    logic [DIV_STAGES-1:0]  r_v;
    t_div_lane              w_a0;
    t_div_lane              w_b0;

    assign w_a0.rem  = '0;
    assign w_a0.word = i_num_a;
    assign w_b0.rem  = '0;
    assign w_b0.word = i_num_b;

    always_comb begin
        n_a[0] = div_step(w_a0, i_den);
        n_b[0] = div_step(w_b0, i_den);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_a[k] = div_step(r_a[k-1], i_den);
            n_b[k] = div_step(r_b[k-1], i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STAGES-2:0], i_valid};
        end
        if (i_en) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_tag[0] <= i_tag;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];
    assign o_quo_a = r_a[DIV_STAGES-1].word;
    assign o_quo_b = r_b[DIV_STAGES-1].word;

endmodule

`default_nettype wire

// ===== hdl/geo_point_to_screen_projector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Projects trail points (latitude/longitude in 1e-7 degree) onto screen pixels
// with a local equirectangular projection around the configured origin, an
// optional heading rotation and a zoom-dependent scale. One request is taken
// per clock while the output is not stalled and the cosine sequencer is idle;
// each result passes the 18-stage pipeline (two 6-stage long dividers, one for
// centimetre scaling and one for the zoom scale). A full stall holds every
// stage in place. After reset and after every write of origin_lat the cosine
// sequencer runs, with i_pt.ready low while it does; other registers are read
// by the stage that uses them, so a write also reaches requests in flight.
// Widths or heights below 3 return zeros with result_valid low.
module geo_point_to_screen_projector import gpsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    gpsp_in_if.sink     i_pt,
    gpsp_out_if.source  o_scr
);

    // ---------------- configuration ----------------
    logic signed [30:0] r_origin_lat;
    logic signed [31:0] r_origin_lon;
    logic signed [11:0] r_head_e;
    logic signed [11:0] r_head_n;
    logic               r_track_up;
    logic [11:0]        r_scr_w;
    logic [11:0]        r_scr_h;
    logic [2:0]         r_zoom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_lat <= '0;
            r_origin_lon <= '0;
            r_head_e     <= '0;
            r_head_n     <= 12'sd1024;
            r_track_up   <= 1'b0;
            r_scr_w      <= 12'd480;
            r_scr_h      <= 12'd272;
            r_zoom       <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_LAT:    r_origin_lat <= $signed(i_cfg_wdata[30:0]);
                CFG_ORIGIN_LON:    r_origin_lon <= $signed(i_cfg_wdata);
                CFG_HEADING_EAST:  r_head_e     <= $signed(i_cfg_wdata[11:0]);
                CFG_HEADING_NORTH: r_head_n     <= $signed(i_cfg_wdata[11:0]);
                CFG_TRACK_UP:      r_track_up   <= i_cfg_wdata[0];
                CFG_SCREEN_WIDTH:  r_scr_w      <= i_cfg_wdata[11:0];
                CFG_SCREEN_HEIGHT: r_scr_h      <= i_cfg_wdata[11:0];
                CFG_ZOOM_LEVEL:    r_zoom       <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // Values derived from configuration only; refreshed every cycle.
    logic signed [11:0] r_he_eff;
    logic signed [11:0] r_hn_eff;
    logic [31:0]        r_cx;       // half width * metres * 2048
    logic [31:0]        r_cy;
    logic [3:0]         r_shift;
    logic [REM_W-1:0]   r_den;
    logic               r_scr_ok;

    always_ff @(posedge i_clk) begin
        r_he_eff <= r_track_up ? r_head_e : 12'sd0;
        r_hn_eff <= r_track_up ? r_head_n : 12'sd1024;
        r_cx     <= ({21'b0, r_scr_w[11:1]} * {22'b0, zoom_metres(r_zoom)}) << 11;
        r_cy     <= ({21'b0, r_scr_h[11:1]} * {22'b0, zoom_metres(r_zoom)}) << 11;
        r_shift  <= zoom_shift(r_zoom);
        r_den    <= zoom_odd(r_zoom);
        r_scr_ok <= (r_scr_w >= 12'd3) && (r_scr_h >= 12'd3);
    end

    // ---------------- cosine of origin latitude ----------------
    logic        w_cos_busy;
    logic [29:0] w_coef;
    logic        w_coef_neg;

    gpsp_cos u_cos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we && (i_cfg_idx == CFG_ORIGIN_LAT)),
        .i_lat      (r_origin_lat),
        .o_busy     (w_cos_busy),
        .o_coef     (w_coef),
        .o_coef_neg (w_coef_neg)
    );

    // ---------------- pipeline control ----------------
    // whole pipe advances unless the output register holds an untaken result
    logic r_ov;
    logic w_en;
    logic w_acc;

    assign w_en       = !r_ov || o_scr.ready;
    assign i_pt.ready = w_en && !w_cos_busy;
    assign w_acc      = i_pt.valid && i_pt.ready;

    // ---------------- stage 1: differences, date line wrap ----------------
    logic               r1_v;
    logic signed [31:0] r1_dlat;
    logic signed [31:0] r1_dlon;
    logic               r1_last;
    logic signed [33:0] w_dlon_raw;
    logic signed [33:0] w_dlon;

    assign w_dlon_raw = 34'(i_pt.point_lon) - 34'(r_origin_lon);
    always_comb begin
        w_dlon = w_dlon_raw;
        if (w_dlon_raw > 34'sd1800000000) begin
            w_dlon = w_dlon_raw - 34'sd3600000000;
        end
        if (w_dlon_raw < -34'sd1800000000) begin
            w_dlon = w_dlon_raw + 34'sd3600000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_acc;
        end
        if (w_en) begin
            r1_dlat <= 32'(i_pt.point_lat) - 32'(r_origin_lat);
            r1_dlon <= w_dlon[31:0];
            r1_last <= i_pt.last_point;
        end
    end

    // ---------------- stage 2: centimetre products (magnitudes) ----------------
    logic        r2_v;
    logic [45:0] r2_nmag;
    logic [60:0] r2_emag;
    logic        r2_nneg;
    logic        r2_eneg;
    logic        r2_last;
    logic [31:0] w_dlat_abs;
    logic [31:0] w_dlon_abs;

    assign w_dlat_abs = r1_dlat[31] ? 32'(-r1_dlat) : 32'(r1_dlat);
    assign w_dlon_abs = r1_dlon[31] ? 32'(-r1_dlon) : 32'(r1_dlon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_nmag <= w_dlat_abs * CM_NUM;
            r2_emag <= w_dlon_abs[30:0] * w_coef;
            r2_nneg <= r1_dlat[31];
            r2_eneg <= r1_dlon[31] ^ w_coef_neg;
            r2_last <= r1_last;
        end
    end

    // ---------------- stages 3-8: divide by 10000 (/16 then /625) ----------------
    logic             w_da_v;
    logic [TAG_W-1:0] w_da_tag;
    logic [DIV_W-1:0] w_da_e;
    logic [DIV_W-1:0] w_da_n;

    gpsp_div u_div_cm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_tag   ({r2_eneg, r2_nneg, r2_last}),
        .i_num_a ({1'b0, r2_emag[60:20]}),
        .i_num_b (r2_nmag[45:4]),
        .i_den   (CM_DEN_ODD),
        .o_valid (w_da_v),
        .o_tag   (w_da_tag),
        .o_quo_a (w_da_e),
        .o_quo_b (w_da_n)
    );

    // ---------------- stage 9: signed east/north ----------------
    logic               r9_v;
    logic signed [32:0] r9_east;
    logic signed [32:0] r9_north;
    logic               r9_last;
    logic signed [32:0] w_e_pos;
    logic signed [32:0] w_n_pos;

    assign w_e_pos = $signed({1'b0, w_da_e[31:0]});
    assign w_n_pos = $signed({1'b0, w_da_n[31:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (w_en) begin
            r9_v <= w_da_v;
        end
        if (w_en) begin
            r9_east  <= w_da_tag[2] ? -w_e_pos : w_e_pos;
            r9_north <= w_da_tag[1] ? -w_n_pos : w_n_pos;
            r9_last  <= w_da_tag[0];
        end
    end

    // ---------------- stage 10: rotation products ----------------
    logic               r10_v;
    logic signed [44:0] r10_ehn;
    logic signed [44:0] r10_nhe;
    logic signed [44:0] r10_nhn;
    logic signed [44:0] r10_ehe;
    logic               r10_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (w_en) begin
            r10_v <= r9_v;
        end
        if (w_en) begin
            r10_ehn  <= r9_east * r_hn_eff;
            r10_nhe  <= r9_north * r_he_eff;
            r10_nhn  <= r9_north * r_hn_eff;
            r10_ehe  <= r9_east * r_he_eff;
            r10_last <= r9_last;
        end
    end

    // ---------------- stage 11: sums, magnitude, power-of-two part ----------------
    logic               r11_v;
    logic [DIV_W-1:0]   r11_xnum;
    logic [DIV_W-1:0]   r11_ynum;
    logic               r11_xneg;
    logic               r11_yneg;
    logic               r11_last;
    logic signed [46:0] w_numx;
    logic signed [46:0] w_numy;
    logic [46:0]        w_xabs;
    logic [46:0]        w_yabs;
    logic [46:0]        w_xsh;
    logic [46:0]        w_ysh;

    assign w_numx = $signed({15'b0, r_cx}) + r10_ehn - r10_nhe;
    assign w_numy = $signed({15'b0, r_cy}) - r10_nhn - r10_ehe;
    assign w_xabs = w_numx[46] ? 47'(-w_numx) : 47'(w_numx);
    assign w_yabs = w_numy[46] ? 47'(-w_numy) : 47'(w_numy);
    assign w_xsh  = w_xabs >> r_shift;
    assign w_ysh  = w_yabs >> r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (w_en) begin
            r11_v <= r10_v;
        end
        if (w_en) begin
            r11_xnum <= w_xsh[DIV_W-1:0];
            r11_ynum <= w_ysh[DIV_W-1:0];
            r11_xneg <= w_numx[46];
            r11_yneg <= w_numy[46];
            r11_last <= r10_last;
        end
    end

    // ---------------- stages 12-17: divide by odd part of the zoom scale ----------------
    logic             w_db_v;
    logic [TAG_W-1:0] w_db_tag;
    logic [DIV_W-1:0] w_db_x;
    logic [DIV_W-1:0] w_db_y;

    gpsp_div u_div_zoom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r11_v),
        .i_tag   ({r11_xneg, r11_yneg, r11_last}),
        .i_num_a (r11_xnum),
        .i_num_b (r11_ynum),
        .i_den   (r_den),
        .o_valid (w_db_v),
        .o_tag   (w_db_tag),
        .o_quo_a (w_db_x),
        .o_quo_b (w_db_y)
    );

    // ---------------- stage 18: clamp, output register ----------------
    logic signed [15:0] r_sx;
    logic signed [15:0] r_sy;
    logic               r_rv;
    logic               r_last;
    logic [15:0]        w_xlim;
    logic [15:0]        w_ylim;

    assign w_xlim = (w_db_x > DIV_W'(SCREEN_LIM)) ? SCREEN_LIM : w_db_x[15:0];
    assign w_ylim = (w_db_y > DIV_W'(SCREEN_LIM)) ? SCREEN_LIM : w_db_y[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_db_v;
        end
        if (w_en) begin
            r_rv   <= r_scr_ok;
            r_last <= w_db_tag[0];
            if (r_scr_ok) begin
                r_sx <= w_db_tag[2] ? -$signed(w_xlim) : $signed(w_xlim);
                r_sy <= w_db_tag[1] ? -$signed(w_ylim) : $signed(w_ylim);
            end else begin
                r_sx <= '0;
                r_sy <= '0;
            end
        end
    end

    assign o_scr.valid        = r_ov;
    assign o_scr.screen_x     = r_sx;
    assign o_scr.screen_y     = r_sy;
    assign o_scr.result_valid = r_rv;
    assign o_scr.last_result  = r_last;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_scr.ready |=> r_ov && $stable(r_sx) && $stable(r_sy))
        else $error("result changed while stalled");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_sx <= 16'sd30000) && (r_sx >= -16'sd30000)
              && (r_sy <= 16'sd30000) && (r_sy >= -16'sd30000))
        else $error("screen coordinate outside clamp range");

    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_rv |-> (r_sx == 16'sd0) && (r_sy == 16'sd0))
        else $error("invalid result carries nonzero coordinates");

    a_cos_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_cos_busy) |-> !w_acc)
        else $error("request taken while cosine recomputes");

endmodule

`default_nettype wire

// ===== test/tb_geo_point_to_screen_projector.sv =====
`timescale 1ns / 1ps

// Testbench for the trail point projector: a queue of point requests feeds a
// clocked driver, a clocked monitor compares each result with the oldest
// predicted screen position. Config is changed only while the block is idle.
module tb_geo_point_to_screen_projector import gpsp_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_wdata;

    gpsp_in_if  pt_if ();
    gpsp_out_if scr_if ();

    geo_point_to_screen_projector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_pt        (pt_if.sink),
        .o_scr       (scr_if.source)
    );

    typedef struct {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic               last;
    } t_point;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               ok;
        logic               last;
    } t_screen;

    // shadow copy of the configuration
    longint        org_lat, org_lon, hdg_e, hdg_n;
    bit            trk_up;
    int unsigned   scr_w, scr_h, zoom;

    t_point  pending_pts[$];
    t_screen expected_scr[$];

    int  n_fail;
    bit  gaps_on;        // random idling enabled
    int  hold_cycles;    // long receiver hold-off, counted down by the monitor

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cosine of |lat| as Q2.16, Horner on Q30 with truncating division
    function automatic longint cos_of_lat(longint lat);
        longint unsigned a, x;
        longint z, r;
        longint coef[6];
        coef = '{-296, 26631, -1491308, 44739243, -536870912, 1073741824};
        a = (lat < 0) ? -lat : lat;
        x = (a * 64'd8048910509) >> 32;
        z = longint'((x * x) >> 30);
        r = 2;
        foreach (coef[k]) r = coef[k] + (z * r) / 64'sd1073741824;
        return r / 16384;
    endfunction

    function automatic longint clamp_px(longint v);
        if (v < -30000) return -30000;
        if (v > 30000) return 30000;
        return v;
    endfunction

    function automatic t_screen project_point(t_point p);
        t_screen s;
        longint dlon, dlat, he, hn, scale, east, north, sx, sy;
        longint metres[6];
        metres = '{20, 50, 100, 200, 500, 1000};
        s.x = 0;
        s.y = 0;
        s.ok = 1'b0;
        s.last = p.last;
        if (scr_w >= 3 && scr_h >= 3) begin
            dlon = longint'(p.lon) - org_lon;
            dlat = longint'(p.lat) - org_lat;
            he = trk_up ? hdg_e : 0;
            hn = trk_up ? hdg_n : 1024;
            scale = metres[zoom < 6 ? zoom : 5] * 2048;
            if (dlon > 64'sd1800000000) dlon -= 64'sd3600000000;
            if (dlon < -64'sd1800000000) dlon += 64'sd3600000000;
            east = (dlon * 11132 * cos_of_lat(org_lat)) / (64'sd10000 * 64'sd65536);
            north = (dlat * 11132) / 10000;
            sx = (longint'(scr_w >> 1) * scale + east * hn - north * he) / scale;
            sy = (longint'(scr_h >> 1) * scale - north * hn - east * he) / scale;
            s.x = 16'(clamp_px(sx));
            s.y = 16'(clamp_px(sy));
            s.ok = 1'b1;
        end
        return s;
    endfunction

    // driver: one request per accepted handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                expected_scr.push_back(project_point('{pt_if.point_lat, pt_if.point_lon,
                                                       pt_if.last_point}));
            end
            if (!pt_if.valid || pt_if.ready) begin
                if (pending_pts.size() > 0 && !(gaps_on && $urandom_range(99) < 14)) begin
                    t_point p;
                    p = pending_pts.pop_front();
                    pt_if.valid      <= 1'b1;
                    pt_if.point_lat  <= p.lat;
                    pt_if.point_lon  <= p.lon;
                    pt_if.last_point <= p.last;
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_if.ready <= 1'b0;
        end else begin
            if (scr_if.valid && scr_if.ready) begin
                if (expected_scr.size() == 0) begin
                    $error("result with nothing pending");
                    n_fail++;
                end else begin
                    t_screen e;
                    e = expected_scr.pop_front();
                    if (scr_if.screen_x !== e.x) begin
                        $error("screen_x exp %0d got %0d", e.x, scr_if.screen_x);
                        n_fail++;
                    end
                    if (scr_if.screen_y !== e.y) begin
                        $error("screen_y exp %0d got %0d", e.y, scr_if.screen_y);
                        n_fail++;
                    end
                    if (scr_if.result_valid !== e.ok) begin
                        $error("result_valid exp %0b got %0b", e.ok, scr_if.result_valid);
                        n_fail++;
                    end
                    if (scr_if.last_result !== e.last) begin
                        $error("last_result exp %0b got %0b", e.last, scr_if.last_result);
                        n_fail++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                scr_if.ready <= 1'b0;
            end else begin
                scr_if.ready <= !(gaps_on && $urandom_range(99) < 14);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ORIGIN_LAT:    org_lat = longint'($signed(val[30:0]));
            CFG_ORIGIN_LON:    org_lon = longint'($signed(val));
            CFG_HEADING_EAST:  hdg_e = longint'($signed(val[11:0]));
            CFG_HEADING_NORTH: hdg_n = longint'($signed(val[11:0]));
            CFG_TRACK_UP:      trk_up = val[0];
            CFG_SCREEN_WIDTH:  scr_w = val[11:0];
            CFG_SCREEN_HEIGHT: scr_h = val[11:0];
            default:           zoom = val[2:0];
        endcase
    endtask

    // wait until every request is through, then let the pipeline drain;
    // checked at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_pts.size() > 0 || pt_if.valid || expected_scr.size() > 0)
            @(negedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic add_point(int lat, int lon, bit last);
        pending_pts.push_back('{31'(lat), 32'(lon), last});
    endtask

    function automatic int rand_in(int lo, int hi);
        return int'(longint'(lo) + longint'($urandom_range(32'(longint'(hi) - lo))));
    endfunction

    // random configuration; most settings stay in range, a few are extremes
    task automatic random_config(int phase);
        int e, n;
        e = rand_in(-1024, 1024);
        n = rand_in(-1024, 1024);
        write_reg(CFG_ORIGIN_LAT, 32'(rand_in(-900000000, 900000000)));
        write_reg(CFG_ORIGIN_LON, 32'(rand_in(-1800000000, 1800000000)));
        write_reg(CFG_HEADING_EAST, 32'(e));
        write_reg(CFG_HEADING_NORTH, 32'(n));
        write_reg(CFG_TRACK_UP, 32'(phase % 3 != 0));
        write_reg(CFG_SCREEN_WIDTH, (phase % 5 == 4) ? $urandom_range(2) : $urandom_range(4095));
        write_reg(CFG_SCREEN_HEIGHT, (phase % 7 == 6) ? $urandom_range(2) : $urandom_range(4095));
        write_reg(CFG_ZOOM_LEVEL, $urandom_range(7));
    endtask

    initial begin
        int dl;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ORIGIN_LAT;
        cfg_wdata = '0;
        pt_if.valid = 1'b0;
        pt_if.point_lat = '0;
        pt_if.point_lon = '0;
        pt_if.last_point = 1'b0;
        scr_if.ready = 1'b0;
        n_fail = 0;
        gaps_on = 1'b0;
        hold_cycles = 0;
        org_lat = 0; org_lon = 0; hdg_e = 0; hdg_n = 1024;
        trk_up = 0; scr_w = 480; scr_h = 272; zoom = 2;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, field extremes, date line wrap
        add_point(0, 0, 0);
        add_point(900000000, 1800000000, 0);
        add_point(-900000000, -1800000000, 1);
        add_point(1073741823, 2147483647, 0);     // beyond stated range
        add_point(-1073741824, -2147483648, 1);
        add_point(1000, -1000, 0);
        wait_idle();
        write_reg(CFG_ORIGIN_LON, 32'(1790000000));
        write_reg(CFG_ORIGIN_LAT, 32'(-900000000));
        write_reg(CFG_TRACK_UP, 1);
        write_reg(CFG_HEADING_EAST, 32'(-1024));
        write_reg(CFG_HEADING_NORTH, 32'(2047)); // not unit length
        write_reg(CFG_ZOOM_LEVEL, 0);
        add_point(-899999000, -1795000000, 0);    // wrap across date line
        add_point(-899999000, 1799999999, 0);
        add_point(0, -1800000000, 1);
        wait_idle();
        write_reg(CFG_ORIGIN_LON, 32'(-1800000000));
        write_reg(CFG_ZOOM_LEVEL, 7);             // above five
        write_reg(CFG_SCREEN_WIDTH, 4095);
        write_reg(CFG_SCREEN_HEIGHT, 3);
        add_point(900000000, 1800000000, 0);
        add_point(-900000000, 1000000, 1);
        wait_idle();
        write_reg(CFG_SCREEN_HEIGHT, 2);          // small screen
        write_reg(CFG_ZOOM_LEVEL, 6);
        add_point(123, 456, 1);
        add_point(-5, 5, 0);
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, 0);
        write_reg(CFG_SCREEN_HEIGHT, 272);
        add_point(7, 7, 1);
        wait_idle();

        // random phases; the second one runs with no idling
        for (int ph = 0; ph < 12; ph++) begin
            random_config(ph);
            gaps_on = (ph != 1);
            for (int k = 0; k < 108; k++) begin
                dl = (k % 4 == 0) ? 32'($urandom) : rand_in(-20000, 20000);
                if (k % 9 == 0)
                    add_point(int'($urandom), int'($urandom), $urandom_range(1));
                else
                    add_point(int'(org_lat) + ((k % 4 == 1) ? rand_in(-900000000,
                              900000000) : rand_in(-20000, 20000)),
                              int'(org_lon) + dl, $urandom_range(1));
            end
            if (ph == 3) hold_cycles = 300;       // fill the pipeline
            wait_idle();
        end

        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
